### sv/psf_pkg.sv
// Shared types and constants for the pairwise shove force pipeline.
package psf_pkg;

  localparam int SPECIES_W     = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int Q88_W         = 16;
  localparam int FORCE_W       = 32;
  localparam int REACH_W       = 34;
  localparam int TSTEP_W       = 33;
  localparam int PROD_HI_W     = 51;
  localparam int PROD_LO_W     = 49;
  localparam int MAG_W         = 49;
  localparam int MAG_LO_W      = 24;
  localparam int PART_HI_W     = 41;
  localparam int PART_LO_W     = 40;
  localparam int FSUM_W        = 65;

  localparam logic [Q88_W-1:0] TIME_STEP_RESET = 16'h0100;
  localparam logic [FORCE_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPECIES0  = 3'd0,
    REG_SPECIES1  = 3'd1,
    REG_SPECIES2  = 3'd2,
    REG_SPECIES3  = 3'd3,
    REG_TIME_STEP = 3'd4,
    REG_THREE_D   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [Q88_W-1:0] limit;
    logic [Q88_W-1:0] factor;
    logic [Q88_W-1:0] scale;
  } species_t;

  typedef struct packed {
    logic [Q88_W-1:0]      radius_a;
    logic [Q88_W-1:0]      radius_b;
    logic [Q88_W-1:0]      distance;
    logic [2:0][Q88_W-1:0] dir;
  } pair_t;

  typedef struct packed {
    logic [31:0]           pa;
    logic [31:0]           pb;
    logic [Q88_W:0]        lsum;
    logic [Q88_W:0]        ssum;
    logic [Q88_W-1:0]      distance;
    logic [2:0][Q88_W-1:0] absd;
    logic [2:0]            neg;
  } s1_t;

  typedef struct packed {
    logic                  shove;
    logic [REACH_W-1:0]    diff;
    logic [TSTEP_W-1:0]    t;
    logic [2:0][Q88_W-1:0] absd;
    logic [2:0]            neg;
  } s2_t;

  typedef struct packed {
    logic                  shove;
    logic [PROD_HI_W-1:0]  a;
    logic [PROD_LO_W-1:0]  b;
    logic [2:0][Q88_W-1:0] absd;
    logic [2:0]            neg;
  } s3_t;

  typedef struct packed {
    logic                  shove;
    logic [MAG_W-1:0]      mag;
    logic [2:0][Q88_W-1:0] absd;
    logic [2:0]            neg;
  } s4_t;

  typedef struct packed {
    logic                      shove;
    logic [2:0][PART_HI_W-1:0] ph;
    logic [2:0][PART_LO_W-1:0] pl;
    logic [2:0]                neg;
  } s5_t;

  typedef struct packed {
    logic                    shoving;
    logic [2:0][FORCE_W-1:0] fa;
    logic [2:0][FORCE_W-1:0] fb;
  } result_t;

endpackage

### sv/psf_cfg.sv
// Configuration registers and per-species parameter lookup.
module psf_cfg #(
  parameter int NUM_SPECIES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [psf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [psf_pkg::SPECIES_W-1:0]   sel_a,
  input  logic [psf_pkg::SPECIES_W-1:0]   sel_b,
  output psf_pkg::species_t               sp_a,
  output psf_pkg::species_t               sp_b,
  output logic [psf_pkg::Q88_W-1:0]       time_step,
  output logic                            three_d
);

  psf_pkg::species_t              params_r [NUM_SPECIES];
  logic [psf_pkg::Q88_W-1:0]      ts_r;
  logic                           td_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SPECIES; i++) params_r[i] <= '0;
      ts_r <= psf_pkg::TIME_STEP_RESET;
      td_r <= 1'b1;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_SPECIES; i++) begin
        if (cfg_index == psf_pkg::CFG_IDX_W'(int'(psf_pkg::REG_SPECIES0) + i)) begin
          params_r[i] <= psf_pkg::species_t'(cfg_data);
        end
      end
      if (cfg_index == psf_pkg::REG_TIME_STEP) ts_r <= cfg_data[psf_pkg::Q88_W-1:0];
      if (cfg_index == psf_pkg::REG_THREE_D) td_r <= cfg_data[0];
    end
  end

  // species beyond the configured count read as zero
  always_comb begin
    sp_a = '0;
    sp_b = '0;
    for (int i = 0; i < NUM_SPECIES; i++) begin
      if (sel_a == psf_pkg::SPECIES_W'(i)) sp_a = params_r[i];
      if (sel_b == psf_pkg::SPECIES_W'(i)) sp_b = params_r[i];
    end
  end

  assign time_step = ts_r;
  assign three_d   = td_r;

endmodule

### sv/psf_front.sv
// Stages 1-2: radius products, reach compare, overlap and time-step scale.
module psf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  input  psf_pkg::pair_t             up_pair,
  input  psf_pkg::species_t          sp_a,
  input  psf_pkg::species_t          sp_b,
  input  logic [psf_pkg::Q88_W-1:0]  time_step,
  output logic                       up_rdy,
  output logic                       dn_valid,
  output psf_pkg::s2_t               dn_data,
  input  logic                       dn_rdy
);

  psf_pkg::s1_t s1_r, s1_nxt;
  psf_pkg::s2_t s2_r, s2_nxt;
  logic v1_r, v2_r, rdy1, rdy2;
  logic [psf_pkg::REACH_W-1:0] reach, dist_q16;

  assign rdy2   = !v2_r || dn_rdy;
  assign rdy1   = !v1_r || rdy2;
  assign up_rdy = rdy1;

  always_comb begin
    s1_nxt.pa       = 32'(sp_a.factor) * 32'(up_pair.radius_a);
    s1_nxt.pb       = 32'(sp_b.factor) * 32'(up_pair.radius_b);
    s1_nxt.lsum     = 17'(sp_a.limit) + 17'(sp_b.limit);
    s1_nxt.ssum     = 17'(sp_a.scale) + 17'(sp_b.scale);
    s1_nxt.distance = up_pair.distance;
    for (int k = 0; k < 3; k++) begin
      s1_nxt.neg[k]  = up_pair.dir[k][psf_pkg::Q88_W-1];
      // most negative code maps to its own magnitude
      s1_nxt.absd[k] = s1_nxt.neg[k] ? (16'd0 - up_pair.dir[k]) : up_pair.dir[k];
    end
  end

  always_comb begin
    reach    = psf_pkg::REACH_W'(s1_r.pa) + psf_pkg::REACH_W'(s1_r.pb)
             + (psf_pkg::REACH_W'(s1_r.lsum) << 15);
    dist_q16 = psf_pkg::REACH_W'({s1_r.distance, 8'h00});
    s2_nxt.shove = dist_q16 <= reach;
    s2_nxt.diff  = reach - dist_q16;
    s2_nxt.t     = psf_pkg::TSTEP_W'(s1_r.ssum) * psf_pkg::TSTEP_W'(time_step);
    s2_nxt.absd  = s1_r.absd;
    s2_nxt.neg   = s1_r.neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
  end

  assign dn_valid = v2_r;
  assign dn_data  = s2_r;

endmodule

### sv/psf_mag.sv
// Stages 3-4: split product of overlap and scale, floored to the magnitude.
module psf_mag (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  psf_pkg::s2_t  up_data,
  output logic          up_rdy,
  output logic          dn_valid,
  output psf_pkg::s4_t  dn_data,
  input  logic          dn_rdy
);

  localparam int SUM_W = psf_pkg::PROD_HI_W + 16;

  psf_pkg::s3_t s3_r, s3_nxt;
  psf_pkg::s4_t s4_r, s4_nxt;
  logic v3_r, v4_r, rdy3, rdy4;
  logic [SUM_W-1:0] msum;

  assign rdy4   = !v4_r || dn_rdy;
  assign rdy3   = !v3_r || rdy4;
  assign up_rdy = rdy3;

  always_comb begin
    s3_nxt.shove = up_data.shove;
    s3_nxt.a     = psf_pkg::PROD_HI_W'(up_data.t)
                 * psf_pkg::PROD_HI_W'(up_data.diff[psf_pkg::REACH_W-1:16]);
    s3_nxt.b     = psf_pkg::PROD_LO_W'(up_data.t) * psf_pkg::PROD_LO_W'(up_data.diff[15:0]);
    s3_nxt.absd  = up_data.absd;
    s3_nxt.neg   = up_data.neg;
  end

  // mag = floor(t * diff / 2^18)
  always_comb begin
    msum         = (SUM_W'(s3_r.a) << 16) + SUM_W'(s3_r.b);
    s4_nxt.shove = s3_r.shove;
    s4_nxt.mag   = msum[SUM_W-1:18];
    s4_nxt.absd  = s3_r.absd;
    s4_nxt.neg   = s3_r.neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= up_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) s3_r <= s3_nxt;
    if (rdy4) s4_r <= s4_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_data  = s4_r;

endmodule

### sv/psf_force.sv
// Stages 5-6: per-axis magnitude times direction, saturation, sign, output register.
module psf_force (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  psf_pkg::s4_t      up_data,
  input  logic              three_d,
  output logic              up_rdy,
  output logic              dn_valid,
  output psf_pkg::result_t  dn_data,
  input  logic              dn_rdy
);

  psf_pkg::s5_t     s5_r, s5_nxt;
  psf_pkg::result_t s6_r, s6_nxt;
  logic v5_r, v6_r, rdy5, rdy6;
  logic [psf_pkg::FSUM_W-1:0]  fsum [3];
  logic [psf_pkg::FORCE_W-1:0] fmag [3];
  logic [2:0]                  keep;

  assign rdy6   = !v6_r || dn_rdy;
  assign rdy5   = !v5_r || rdy6;
  assign up_rdy = rdy5;

  always_comb begin
    s5_nxt.shove = up_data.shove;
    s5_nxt.neg   = up_data.neg;
    for (int k = 0; k < 3; k++) begin
      s5_nxt.ph[k] = psf_pkg::PART_HI_W'(up_data.mag[psf_pkg::MAG_W-1:psf_pkg::MAG_LO_W])
                   * psf_pkg::PART_HI_W'(up_data.absd[k]);
      s5_nxt.pl[k] = psf_pkg::PART_LO_W'(up_data.mag[psf_pkg::MAG_LO_W-1:0])
                   * psf_pkg::PART_LO_W'(up_data.absd[k]);
    end
  end

  always_comb begin
    keep = {s5_r.shove && three_d, s5_r.shove, s5_r.shove};
    s6_nxt.shoving = s5_r.shove;
    for (int k = 0; k < 3; k++) begin
      fsum[k] = (psf_pkg::FSUM_W'(s5_r.ph[k]) << psf_pkg::MAG_LO_W)
              + psf_pkg::FSUM_W'(s5_r.pl[k]);
      fmag[k] = (|fsum[k][psf_pkg::FSUM_W-1:53]) ? psf_pkg::FORCE_MAX
              : fsum[k][53:22];
      if (!keep[k]) begin
        s6_nxt.fa[k] = '0;
        s6_nxt.fb[k] = '0;
      end else if (s5_r.neg[k]) begin
        s6_nxt.fa[k] = 32'd0 - fmag[k];
        s6_nxt.fb[k] = fmag[k];
      end else begin
        s6_nxt.fa[k] = fmag[k];
        s6_nxt.fb[k] = 32'd0 - fmag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy5) v5_r <= up_valid;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) s5_r <= s5_nxt;
    if (rdy6) s6_r <= s6_nxt;
  end

  assign dn_valid = v6_r;
  assign dn_data  = s6_r;

endmodule

### sv/pairwise_shove_force.sv
// Top level of the pairwise shove force pipeline.
//
//   channel   direction  handshake            word
//   in_       input      in_valid / in_stall  species pair, radii, distance, direction
//   out_      output     out_valid/out_stall  shoving flag, forces on a and b
//   cfg_      input      cfg_we               register index and data
//
// Six register stages, set by the split overlap-by-scale product and the
// split direction multiply; one word per cycle while the output is not stalled.
// Each stage holds its own valid bit and advances when the next stage is
// empty or moving, so bubbles close up under a stalled output.
// Synchronous active-low reset empties the pipe and loads register defaults.
module pairwise_shove_force #(
  parameter int NUM_SPECIES = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_species_a,
  input  logic [1:0]                     in_species_b,
  input  logic [15:0]                    in_radius_a,
  input  logic [15:0]                    in_radius_b,
  input  logic [15:0]                    in_distance,
  input  logic signed [15:0]             in_dir_x,
  input  logic signed [15:0]             in_dir_y,
  input  logic signed [15:0]             in_dir_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_shoving,
  output logic signed [31:0]             out_force_a_x,
  output logic signed [31:0]             out_force_a_y,
  output logic signed [31:0]             out_force_a_z,
  output logic signed [31:0]             out_force_b_x,
  output logic signed [31:0]             out_force_b_y,
  output logic signed [31:0]             out_force_b_z
);

  psf_pkg::species_t         sp_a, sp_b;
  logic [psf_pkg::Q88_W-1:0] time_step;
  logic                      three_d;
  psf_pkg::pair_t            pair;
  psf_pkg::s2_t              s2;
  psf_pkg::s4_t              s4;
  psf_pkg::result_t          res;
  logic front_rdy, s2_valid, mag_rdy, s4_valid, force_rdy;

  psf_cfg #(.NUM_SPECIES(NUM_SPECIES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sel_a     (in_species_a),
    .sel_b     (in_species_b),
    .sp_a      (sp_a),
    .sp_b      (sp_b),
    .time_step (time_step),
    .three_d   (three_d)
  );

  assign pair.radius_a = in_radius_a;
  assign pair.radius_b = in_radius_b;
  assign pair.distance = in_distance;
  assign pair.dir[0]   = in_dir_x;
  assign pair.dir[1]   = in_dir_y;
  assign pair.dir[2]   = in_dir_z;

  psf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_pair   (pair),
    .sp_a      (sp_a),
    .sp_b      (sp_b),
    .time_step (time_step),
    .up_rdy    (front_rdy),
    .dn_valid  (s2_valid),
    .dn_data   (s2),
    .dn_rdy    (mag_rdy)
  );

  psf_mag u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_data  (s2),
    .up_rdy   (mag_rdy),
    .dn_valid (s4_valid),
    .dn_data  (s4),
    .dn_rdy   (force_rdy)
  );

  psf_force u_force (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s4_valid),
    .up_data  (s4),
    .three_d  (three_d),
    .up_rdy   (force_rdy),
    .dn_valid (out_valid),
    .dn_data  (res),
    .dn_rdy   (!out_stall)
  );

  assign in_stall      = !front_rdy;
  assign out_shoving   = res.shoving;
  assign out_force_a_x = res.fa[0];
  assign out_force_a_y = res.fa[1];
  assign out_force_a_z = res.fa[2];
  assign out_force_b_x = res.fb[0];
  assign out_force_b_y = res.fb[1];
  assign out_force_b_z = res.fb[2];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_b_negates_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_force_a_x + out_force_b_x) == 32'd0)
               && (32'(out_force_a_y + out_force_b_y) == 32'd0)
               && (32'(out_force_a_z + out_force_b_z) == 32'd0))
    else $error("force on b is not the negation of force on a");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_shoving |-> out_force_a_x == 32'sd0 && out_force_a_y == 32'sd0
                                  && out_force_a_z == 32'sd0)
    else $error("nonzero force without overlap");

  a_z_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !three_d |-> out_force_a_z == 32'sd0 && out_force_b_z == 32'sd0)
    else $error("z force in two-dimensional mode");

endmodule

### sim/shove_force_check.sv
// Scoreboard for the pairwise shove force block: predicts each result word and compares it.
module shove_force_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_species_a,
  input  logic [1:0]                    in_species_b,
  input  logic [15:0]                   in_radius_a,
  input  logic [15:0]                   in_radius_b,
  input  logic [15:0]                   in_distance,
  input  logic [15:0]                   in_dir_x,
  input  logic [15:0]                   in_dir_y,
  input  logic [15:0]                   in_dir_z,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_shoving,
  input  logic [31:0]                   out_force_a_x,
  input  logic [31:0]                   out_force_a_y,
  input  logic [31:0]                   out_force_a_z,
  input  logic [31:0]                   out_force_b_x,
  input  logic [31:0]                   out_force_b_y,
  input  logic [31:0]                   out_force_b_z,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen,
  output int                            contacts_seen
);

  psf_pkg::species_t species_cfg [4];
  logic [15:0]       tstep;
  logic              three_d;
  psf_pkg::result_t  expected_forces [$];
  string             axis_name [3] = '{"x", "y", "z"};

  // |dir| * mag in Q.30, down to Q24.8, saturated before the sign goes back on
  function automatic logic [psf_pkg::FORCE_W-1:0] dir_force(input logic [127:0] mag,
                                                            input logic [15:0] dir);
    logic [15:0]                 dir_abs;
    logic [127:0]                prod;
    logic [psf_pkg::FORCE_W-1:0] m;
    dir_abs = dir[15] ? (~dir + 16'd1) : dir;
    prod = (mag * 128'(dir_abs)) >> 22;
    m = (prod > 128'(psf_pkg::FORCE_MAX)) ? psf_pkg::FORCE_MAX : prod[psf_pkg::FORCE_W-1:0];
    return dir[15] ? (~m + 32'd1) : m;
  endfunction

  function automatic psf_pkg::result_t predict_shove(input logic [1:0] sa, sb,
                                                     input logic [15:0] ra, rb, sep,
                                                     input logic [15:0] dx, dy, dz);
    psf_pkg::species_t pa, pb;
    logic [127:0]      reach, dist_q16, mag;
    psf_pkg::result_t  r;
    pa = species_cfg[sa];
    pb = species_cfg[sb];
    reach = 128'(pa.factor) * 128'(ra) + 128'(pb.factor) * 128'(rb)
          + ((128'(pa.limit) + 128'(pb.limit)) << 15);
    dist_q16 = 128'(sep) << 8;
    r = '0;
    if (dist_q16 <= reach) begin
      mag = ((128'(pa.scale) + 128'(pb.scale)) * 128'(tstep) * (reach - dist_q16)) >> 18;
      r.shoving = 1'b1;
      r.fa[0] = dir_force(mag, dx);
      r.fa[1] = dir_force(mag, dy);
      r.fa[2] = three_d ? dir_force(mag, dz) : '0;
      for (int k = 0; k < 3; k++) r.fb[k] = -r.fa[k];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    psf_pkg::result_t want, got;
    if (!rst_n) begin
      foreach (species_cfg[i]) species_cfg[i] = '0;
      tstep = psf_pkg::TIME_STEP_RESET;
      three_d = 1'b1;
      expected_forces.delete();
      fail_count = 0;
      results_seen = 0;
      contacts_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.shoving = out_shoving;
        got.fa[0] = out_force_a_x;
        got.fa[1] = out_force_a_y;
        got.fa[2] = out_force_a_z;
        got.fb[0] = out_force_b_x;
        got.fb[1] = out_force_b_y;
        got.fb[2] = out_force_b_z;
        if (expected_forces.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing outstanding: shoving %0b force_a_x %0d",
                   $time, got.shoving, $signed(got.fa[0]));
        end else begin
          want = expected_forces.pop_front();
          results_seen++;
          if (want.shoving) contacts_seen++;
          if (got.shoving !== want.shoving) begin
            fail_count++;
            $display("%0t: shoving expected %0b got %0b", $time, want.shoving, got.shoving);
          end
          for (int k = 0; k < 3; k++) begin
            if (got.fa[k] !== want.fa[k]) begin
              fail_count++;
              $display("%0t: force_a_%s expected %0d got %0d", $time, axis_name[k],
                       $signed(want.fa[k]), $signed(got.fa[k]));
            end
            if (got.fb[k] !== want.fb[k]) begin
              fail_count++;
              $display("%0t: force_b_%s expected %0d got %0d", $time, axis_name[k],
                       $signed(want.fb[k]), $signed(got.fb[k]));
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_forces.push_back(predict_shove(in_species_a, in_species_b, in_radius_a,
                                                in_radius_b, in_distance, in_dir_x,
                                                in_dir_y, in_dir_z));
      if (cfg_we) begin
        case (cfg_index)
          psf_pkg::REG_SPECIES0, psf_pkg::REG_SPECIES1,
          psf_pkg::REG_SPECIES2, psf_pkg::REG_SPECIES3:
            species_cfg[cfg_index[1:0]] = psf_pkg::species_t'(cfg_data);
          psf_pkg::REG_TIME_STEP: tstep = cfg_data[15:0];
          psf_pkg::REG_THREE_D:   three_d = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = expected_forces.size();
  end

endmodule

### sim/pairwise_shove_force_tb.sv
// Testbench top for the pairwise shove force block: stimulus, register settings and verdict.
module pairwise_shove_force_tb;

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ROUNDS       = 6;
  localparam int ROUND_WORDS  = 135;
  localparam logic [psf_pkg::CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [psf_pkg::CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  typedef enum int {FLOW, RANDOM_STALL, PATTERN_STALL, HEAVY_STALL} stall_mode_t;

  typedef struct packed {
    logic [1:0]  sa;
    logic [1:0]  sb;
    logic [15:0] ra;
    logic [15:0] rb;
    logic [15:0] sep;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] dz;
  } pair_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [psf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [psf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_species_a = '0;
  logic [1:0]                     in_species_b = '0;
  logic [15:0]                    in_radius_a = '0;
  logic [15:0]                    in_radius_b = '0;
  logic [15:0]                    in_distance = '0;
  logic signed [15:0]             in_dir_x = '0;
  logic signed [15:0]             in_dir_y = '0;
  logic signed [15:0]             in_dir_z = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_shoving;
  logic signed [31:0]             out_force_a_x, out_force_a_y, out_force_a_z;
  logic signed [31:0]             out_force_b_x, out_force_b_y, out_force_b_z;

  int                fail_count, pending, results_seen, contacts_seen;
  int                quiet_cycles = 0;
  int                words_sent = 0;
  int                settings_used = 1;
  int                burst_left = 0;
  psf_pkg::species_t species_mirror [4];
  stall_mode_t       stall_mode = FLOW;
  int                stall_mode_left = 0;
  logic [7:0]        stall_pattern = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pairwise_shove_force u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_species_a, .in_species_b, .in_radius_a, .in_radius_b,
    .in_distance, .in_dir_x, .in_dir_y, .in_dir_z,
    .out_valid, .out_stall, .out_shoving,
    .out_force_a_x, .out_force_a_y, .out_force_a_z,
    .out_force_b_x, .out_force_b_y, .out_force_b_z
  );

  shove_force_check u_check (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_species_a, .in_species_b, .in_radius_a, .in_radius_b,
    .in_distance, .in_dir_x, .in_dir_y, .in_dir_z,
    .out_valid, .out_stall, .out_shoving,
    .out_force_a_x, .out_force_a_y, .out_force_a_z,
    .out_force_b_x, .out_force_b_y, .out_force_b_z,
    .fail_count, .pending, .results_seen, .contacts_seen
  );

  // receiver stall pattern, switching between randomly chosen modes
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(32, 256);
      stall_pattern = 8'($urandom_range(0, 255)) & 8'hFE;
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      FLOW:         out_stall = 1'b0;
      RANDOM_STALL: out_stall = ($urandom_range(0, 2) == 0);
      PATTERN_STALL: begin
        out_stall = stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      end
      default:      out_stall = ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic pair_word_t make_pair(input logic [1:0] sa, sb,
                                           input logic [15:0] ra, rb, sep, dx, dy, dz);
    pair_word_t w;
    w.sa = sa;
    w.sb = sb;
    w.ra = ra;
    w.rb = rb;
    w.sep = sep;
    w.dx = dx;
    w.dy = dy;
    w.dz = dz;
    return w;
  endfunction

  // largest distance that still touches, clipped to the field
  function automatic logic [15:0] contact_dist(input logic [1:0] sa, sb,
                                               input logic [15:0] ra, rb);
    logic [63:0] reach;
    reach = 64'(species_mirror[sa].factor) * 64'(ra) + 64'(species_mirror[sb].factor) * 64'(rb)
          + ((64'(species_mirror[sa].limit) + 64'(species_mirror[sb].limit)) << 15);
    reach = reach >> 8;
    return (reach > 64'hFFFF) ? 16'hFFFF : reach[15:0];
  endfunction

  function automatic logic [15:0] rand_dir();
    int v;
    if ($urandom_range(0, 7) == 0) return 16'($urandom_range(0, 16'hFFFF));
    v = int'($urandom_range(0, 32768)) - 16384;
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_q88();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'($urandom_range(0, 16'h0200));
    endcase
  endfunction

  function automatic pair_word_t random_pair();
    pair_word_t  w;
    logic [15:0] reach_d;
    int          pick;
    w.sa = 2'($urandom_range(0, 3));
    w.sb = 2'($urandom_range(0, 3));
    w.ra = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h0800))
                                : 16'($urandom_range(0, 16'hFFFF));
    w.rb = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h0800))
                                : 16'($urandom_range(0, 16'hFFFF));
    reach_d = contact_dist(w.sa, w.sb, w.ra, w.rb);
    pick = $urandom_range(0, 9);
    if (pick < 5)       w.sep = 16'($urandom_range(0, reach_d));
    else if (pick == 5) w.sep = reach_d;
    else if (pick == 6) w.sep = (reach_d == 16'hFFFF) ? reach_d : reach_d + 16'd1;
    else                w.sep = 16'($urandom_range(0, 16'hFFFF));
    w.dx = rand_dir();
    w.dy = rand_dir();
    w.dz = rand_dir();
    return w;
  endfunction

  task automatic write_reg(input logic [psf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psf_pkg::CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx <= psf_pkg::REG_SPECIES3) species_mirror[idx[1:0]] = psf_pkg::species_t'(data);
  endtask

  task automatic load_uniform(input logic [psf_pkg::CFG_DATA_W-1:0] sp, input logic [15:0] ts,
                              input logic td);
    for (int k = 0; k < 4; k++)
      write_reg(psf_pkg::CFG_IDX_W'(int'(psf_pkg::REG_SPECIES0) + k), sp);
    write_reg(psf_pkg::REG_TIME_STEP, psf_pkg::CFG_DATA_W'(ts));
    write_reg(psf_pkg::REG_THREE_D, psf_pkg::CFG_DATA_W'(td));
  endtask

  task automatic load_random();
    for (int k = 0; k < 4; k++)
      write_reg(psf_pkg::CFG_IDX_W'(int'(psf_pkg::REG_SPECIES0) + k),
                {rand_q88(), rand_q88(), rand_q88()});
    write_reg(psf_pkg::REG_TIME_STEP, {$urandom, rand_q88()});
    write_reg(psf_pkg::REG_THREE_D, {$urandom, 16'($urandom)});
    write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, {$urandom, 16'($urandom)});
  endtask

  task automatic send_pair(input pair_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_species_a = w.sa;
    in_species_b = w.sb;
    in_radius_a = w.ra;
    in_radius_b = w.rb;
    in_distance = w.sep;
    in_dir_x = w.dx;
    in_dir_y = w.dy;
    in_dir_z = w.dz;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  initial begin
    logic [15:0] d;
    foreach (species_mirror[i]) species_mirror[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // register defaults: zero species, unit time step, 3-D
    send_pair(make_pair(2'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'hC000, 16'h4000));
    send_pair(make_pair(2'd1, 2'd2, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h4000, 16'h4000, 16'h4000));
    send_pair(make_pair(2'd3, 2'd3, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF));

    wait_drained();
    write_reg(psf_pkg::REG_SPECIES0, {16'h0080, 16'h0100, 16'h0100});
    write_reg(psf_pkg::REG_SPECIES1, {16'h0100, 16'h0080, 16'h0200});
    write_reg(psf_pkg::REG_SPECIES2, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_reg(psf_pkg::REG_SPECIES3, '0);
    write_reg(psf_pkg::REG_TIME_STEP, psf_pkg::CFG_DATA_W'(16'h0100));
    write_reg(psf_pkg::REG_THREE_D, psf_pkg::CFG_DATA_W'(1'b1));
    write_reg(REG_UNUSED_6, '1);
    write_reg(REG_UNUSED_7, '1);
    settings_used++;
    send_pair(make_pair(2'd0, 2'd1, 16'h0200, 16'h0300, 16'h0100, 16'h4000, 16'h0000, 16'h0000));
    send_pair(make_pair(2'd1, 2'd0, 16'h0300, 16'h0200, 16'h0100, 16'hC000, 16'h4000, 16'hC000));
    send_pair(make_pair(2'd0, 2'd1, 16'h0200, 16'h0300, 16'h0040, 16'h8000, 16'h8000, 16'h8000));
    send_pair(make_pair(2'd1, 2'd1, 16'h0400, 16'h0400, 16'h0000, 16'h7FFF, 16'h8001, 16'h2D41));
    // exactly at contact, then one step beyond
    d = contact_dist(2'd0, 2'd1, 16'h0200, 16'h0300);
    send_pair(make_pair(2'd0, 2'd1, 16'h0200, 16'h0300, d, 16'h4000, 16'h4000, 16'h4000));
    send_pair(make_pair(2'd0, 2'd1, 16'h0200, 16'h0300, d + 16'd1, 16'h4000, 16'h4000,
                        16'h4000));
    // huge overlap saturates
    send_pair(make_pair(2'd2, 2'd2, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h4000, 16'hC000));
    send_pair(make_pair(2'd2, 2'd3, 16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h8001, 16'h0001));
    send_pair(make_pair(2'd3, 2'd3, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h4000));
    send_pair(make_pair(2'd0, 2'd0, 16'h0001, 16'h0001, 16'hFFFF, 16'h4000, 16'h4000, 16'h4000));
    send_pair(make_pair(2'd3, 2'd2, 16'h0100, 16'h0100, 16'h8000, 16'hE000, 16'h2000, 16'h3000));

    wait_drained();
    write_reg(psf_pkg::REG_THREE_D, psf_pkg::CFG_DATA_W'(1'b0));
    settings_used++;
    send_pair(make_pair(2'd0, 2'd1, 16'h0200, 16'h0300, 16'h0100, 16'h2000, 16'h2000, 16'h4000));
    send_pair(make_pair(2'd2, 2'd2, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h4000, 16'h4000, 16'h8000));

    wait_drained();
    write_reg(psf_pkg::REG_TIME_STEP, psf_pkg::CFG_DATA_W'(16'hFFFF));
    write_reg(psf_pkg::REG_THREE_D, psf_pkg::CFG_DATA_W'(1'b1));
    settings_used++;
    send_pair(make_pair(2'd0, 2'd1, 16'h0200, 16'h0300, 16'h0000, 16'h4000, 16'hC000, 16'h8000));
    send_pair(make_pair(2'd1, 2'd2, 16'h0800, 16'h0800, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100));

    for (int r = 0; r < ROUNDS; r++) begin
      wait_drained();
      if (r == 0)      load_uniform('1, 16'hFFFF, 1'b1);
      else if (r == 1) load_uniform('0, 16'h0000, 1'b0);
      else             load_random();
      settings_used++;
      for (int n = 0; n < ROUND_WORDS; n++) begin
        if (n == ROUND_WORDS / 2) wait_drained();
        send_pair(random_pair());
      end
    end
    wait_drained();

    $display("Sent %0d pair words across %0d register settings %s.", words_sent,
             settings_used, "(reset values, all-ones, all-zero)");
    $display("Checked %0d result words, %0d of them in contact.", results_seen, contacts_seen);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
